FILE: rtl/core/pdrm_pkg.sv
// Shared types, codes and constants for the pump dry-run emergency monitor.
package pdrm_pkg;

    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned LIMIT_W   = 26;  // 65535 s in ms fits in 26 bits
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [LIMIT_W-1:0] MS_PER_S          = LIMIT_W'(1000);
    localparam logic [TIME_W-1:0]  LONG_PRESS_MS     = TIME_W'(3000);
    localparam logic [TIME_W-1:0]  ROTATION_GUARD_MS = TIME_W'(200);

    localparam logic [TIMEOUT_W-1:0] DRY_TIMEOUT_RST = TIMEOUT_W'(60);
    localparam logic [LEVEL_W-1:0]   MIN_CHANGE_RST  = LEVEL_W'(2);
    localparam logic [COUNT_W-1:0]   FAIL_LIMIT_RST  = COUNT_W'(3);
    localparam logic [LEVEL_W-1:0]   LEVEL_MIN_RST   = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX_RST   = LEVEL_W'(1023);

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    typedef enum logic [2:0] {
        REG_DRY_TIMEOUT = 3'd0,
        REG_MIN_CHANGE  = 3'd1,
        REG_FAIL_LIMIT  = 3'd2,
        REG_TANK1_MIN   = 3'd3,
        REG_TANK1_MAX   = 3'd4,
        REG_TANK2_MIN   = 3'd5,
        REG_TANK2_MAX   = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        EXIT_NONE   = 2'd0,
        EXIT_LEVELS = 2'd1,
        EXIT_PRESS  = 2'd2
    } exit_cause_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit_ms;
        logic [LEVEL_W-1:0] min_change;
        logic [COUNT_W-1:0] fail_limit;
        logic [LEVEL_W-1:0] tank1_min;
        logic [LEVEL_W-1:0] tank1_max;
        logic [LEVEL_W-1:0] tank2_min;
        logic [LEVEL_W-1:0] tank2_max;
    } cfg_t;

    typedef struct packed {
        logic        emergency_active;
        logic        dry_run_pump1;
        logic        dry_run_pump2;
        exit_cause_t exit_cause;
        logic        relays_off;
    } res_t;

endpackage

FILE: rtl/core/pdrm_item_if.sv
// Input channel carrying one check or reset item per beat.
interface pdrm_item_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] now_ms;
    logic        pump1_on;
    logic        pump2_on;
    logic [9:0]  tank1_level;
    logic [9:0]  tank2_level;
    logic        button_pressed;
    logic [31:0] last_rotation_ms;

    modport source (
        output valid, req_type, now_ms, pump1_on, pump2_on, tank1_level, tank2_level,
               button_pressed, last_rotation_ms,
        input  ready
    );
    modport sink (
        input  valid, req_type, now_ms, pump1_on, pump2_on, tank1_level, tank2_level,
               button_pressed, last_rotation_ms,
        output ready
    );
endinterface

FILE: rtl/core/pdrm_result_if.sv
// Output channel carrying one result per beat.
interface pdrm_result_if;
    logic       valid;
    logic       ready;
    logic       emergency_active;
    logic       dry_run_pump1;
    logic       dry_run_pump2;
    logic [1:0] exit_cause;
    logic       relays_off;

    modport source (
        output valid, emergency_active, dry_run_pump1, dry_run_pump2, exit_cause, relays_off,
        input  ready
    );
    modport sink (
        input  valid, emergency_active, dry_run_pump1, dry_run_pump2, exit_cause, relays_off,
        output ready
    );
endinterface

FILE: rtl/core/pdrm_cfg.sv
// APB register bank holding the monitor thresholds and timeout.
module pdrm_cfg
    import pdrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    logic [TIMEOUT_W-1:0] dry_timeout_reg;
    logic [LIMIT_W-1:0]   limit_ms_reg;
    logic [LEVEL_W-1:0]   min_change_reg;
    logic [COUNT_W-1:0]   fail_limit_reg;
    logic [LEVEL_W-1:0]   tank1_min_reg;
    logic [LEVEL_W-1:0]   tank1_max_reg;
    logic [LEVEL_W-1:0]   tank2_min_reg;
    logic [LEVEL_W-1:0]   tank2_max_reg;
    logic                 wr_en;
    logic [2:0]           idx;
    logic [LIMIT_W-1:0]   limit_ms_next;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[PADDR_W-1:2];
    // timeout converted to ms once, at write time
    assign limit_ms_next = LIMIT_W'(pwdata[TIMEOUT_W-1:0]) * MS_PER_S;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_timeout_reg <= DRY_TIMEOUT_RST;
            limit_ms_reg    <= LIMIT_W'(DRY_TIMEOUT_RST) * MS_PER_S;
            min_change_reg  <= MIN_CHANGE_RST;
            fail_limit_reg  <= FAIL_LIMIT_RST;
            tank1_min_reg   <= LEVEL_MIN_RST;
            tank1_max_reg   <= LEVEL_MAX_RST;
            tank2_min_reg   <= LEVEL_MIN_RST;
            tank2_max_reg   <= LEVEL_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DRY_TIMEOUT:
                begin
                    dry_timeout_reg <= pwdata[TIMEOUT_W-1:0];
                    limit_ms_reg    <= limit_ms_next;
                end
                REG_MIN_CHANGE: min_change_reg <= pwdata[LEVEL_W-1:0];
                REG_FAIL_LIMIT: fail_limit_reg <= pwdata[COUNT_W-1:0];
                REG_TANK1_MIN:  tank1_min_reg  <= pwdata[LEVEL_W-1:0];
                REG_TANK1_MAX:  tank1_max_reg  <= pwdata[LEVEL_W-1:0];
                REG_TANK2_MIN:  tank2_min_reg  <= pwdata[LEVEL_W-1:0];
                REG_TANK2_MAX:  tank2_max_reg  <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DRY_TIMEOUT: prdata = PDATA_W'(dry_timeout_reg);
            REG_MIN_CHANGE:  prdata = PDATA_W'(min_change_reg);
            REG_FAIL_LIMIT:  prdata = PDATA_W'(fail_limit_reg);
            REG_TANK1_MIN:   prdata = PDATA_W'(tank1_min_reg);
            REG_TANK1_MAX:   prdata = PDATA_W'(tank1_max_reg);
            REG_TANK2_MIN:   prdata = PDATA_W'(tank2_min_reg);
            REG_TANK2_MAX:   prdata = PDATA_W'(tank2_max_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.limit_ms   = limit_ms_reg;
    assign cfg.min_change = min_change_reg;
    assign cfg.fail_limit = fail_limit_reg;
    assign cfg.tank1_min  = tank1_min_reg;
    assign cfg.tank1_max  = tank1_max_reg;
    assign cfg.tank2_min  = tank2_min_reg;
    assign cfg.tank2_max  = tank2_max_reg;

endmodule

FILE: rtl/core/pdrm_lane.sv
// One pump lane: start capture, timeout check and failure counting.
module pdrm_lane
    import pdrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               check,
    input  logic               pump_on,
    input  logic [LEVEL_W-1:0] level,
    input  logic [TIME_W-1:0]  now_ms,
    input  cfg_t               cfg,
    output logic               dry_run
);

    logic               active_reg,      active_next;
    logic [LEVEL_W-1:0] start_level_reg, start_level_next;
    logic [TIME_W-1:0]  start_time_reg,  start_time_next;
    logic [COUNT_W-1:0] fail_count_reg,  fail_count_next;
    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] delta;
    logic [COUNT_W-1:0] fail_inc;

    assign elapsed  = now_ms - start_time_reg;
    assign delta    = (level >= start_level_reg) ? level - start_level_reg
                                                 : start_level_reg - level;
    assign fail_inc = (fail_count_reg == {COUNT_W{1'b1}}) ? fail_count_reg
                                                          : fail_count_reg + 1'b1;

    always_comb
    begin
        active_next      = active_reg;
        start_level_next = start_level_reg;
        start_time_next  = start_time_reg;
        fail_count_next  = fail_count_reg;
        dry_run          = 1'b0;
        if (check)
        begin
            if (!pump_on)
            begin
                if (active_reg)
                begin
                    active_next     = 1'b0;
                    fail_count_next = '0;
                end
            end
            else if (!active_reg)
            begin
                active_next      = 1'b1;
                start_level_next = level;
                start_time_next  = now_ms;
                fail_count_next  = '0;
            end
            else if (elapsed >= TIME_W'(cfg.limit_ms))
            begin
                if (delta < cfg.min_change)
                begin
                    fail_count_next = fail_inc;
                    if (fail_inc >= cfg.fail_limit)
                    begin
                        active_next = 1'b0;
                        dry_run     = 1'b1;
                    end
                end
                else
                begin
                    fail_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            start_level_reg <= '0;
            start_time_reg  <= '0;
            fail_count_reg  <= '0;
        end
        else
        begin
            active_reg      <= active_next;
            start_level_reg <= start_level_next;
            start_time_reg  <= start_time_next;
            fail_count_reg  <= fail_count_next;
        end
    end

endmodule

FILE: rtl/core/pdrm_merge.sv
// Merge stage: emergency latch, exit checks, press timer and result register.
module pdrm_merge
    import pdrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               req_type,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic [LEVEL_W-1:0] tank1_level,
    input  logic [LEVEL_W-1:0] tank2_level,
    input  logic               button_pressed,
    input  logic [TIME_W-1:0]  last_rotation_ms,
    input  logic               dry1,
    input  logic               dry2,
    input  cfg_t               cfg,
    input  logic               res_ready,
    output logic               res_valid,
    output res_t               res
);

    logic              emergency_reg, emergency_next;
    logic              press_held_reg, press_held_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic              valid_reg, valid_next;
    res_t              res_reg, res_next;
    logic              ok1, ok2;
    logic              guard_clear;
    logic              long_press;

    assign ok1 = (tank1_level >= cfg.tank1_min) && (tank1_level <= cfg.tank1_max);
    assign ok2 = (tank2_level >= cfg.tank2_min) && (tank2_level <= cfg.tank2_max);
    assign guard_clear = (now_ms - last_rotation_ms) >= ROTATION_GUARD_MS;
    assign long_press  = (now_ms - press_start_reg) >= LONG_PRESS_MS;

    always_comb
    begin
        emergency_next   = emergency_reg;
        press_held_next  = press_held_reg;
        press_start_next = press_start_reg;
        res_next         = '0;
        res_next.exit_cause = EXIT_NONE;
        if (req_type == REQ_CHECK)
        begin
            res_next.dry_run_pump1 = dry1;
            res_next.dry_run_pump2 = dry2;
            if (dry1 || dry2)
            begin
                emergency_next      = 1'b1;
                res_next.relays_off = 1'b1;
            end
        end
        else
        begin
            if (emergency_reg && ok1 && ok2)
            begin
                emergency_next      = 1'b0;
                res_next.relays_off = 1'b1;
                res_next.exit_cause = EXIT_LEVELS;
            end
            if (button_pressed)
            begin
                if (guard_clear)
                begin
                    if (!press_held_reg)
                    begin
                        press_held_next  = 1'b1;
                        press_start_next = now_ms;
                    end
                    else if (long_press)
                    begin
                        emergency_next      = 1'b0;
                        res_next.relays_off = 1'b1;
                        res_next.exit_cause = EXIT_PRESS;
                        press_held_next     = 1'b0;
                        press_start_next    = '0;
                    end
                end
            end
            else
            begin
                press_held_next  = 1'b0;
                press_start_next = '0;
            end
        end
        res_next.emergency_active = emergency_next;
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emergency_reg   <= 1'b0;
            press_held_reg  <= 1'b0;
            press_start_reg <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                emergency_reg   <= emergency_next;
                press_held_reg  <= press_held_next;
                press_start_reg <= press_start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/core/pump_dry_run_emergency_monitor.sv
// Top level of the two-pump dry-run monitor with emergency latch.
// Channels: item (sink) takes check or reset items, result (source) gives one
// result beat per item; an APB-style port holds the thresholds and timeout.
// Each accepted item is judged in the cycle it is taken: the two pump lanes
// run side by side and the merge stage updates the latch and registers the
// result, which is offered in the cycle after acceptance.
// Throughput is one item per cycle while results are taken; the result register is the only stage.
// item.ready is high whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the pending result and
// blocks further items until it is taken.
// Reset clears all lane and latch state, empties the result register and
// loads the register defaults; no clearing pass is needed.
// The user must write configuration only while no item is in flight; the block does not enforce it.
module pump_dry_run_emergency_monitor
    import pdrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    pdrm_item_if.sink          item,
    pdrm_result_if.source      result
);

    cfg_t cfg;
    logic accept;
    logic check;
    logic dry1, dry2;
    logic res_valid;
    res_t res;

    assign pready     = 1'b1;
    assign item.ready = !res_valid || result.ready;
    assign accept     = item.valid && item.ready;
    assign check      = accept && (item.req_type == REQ_CHECK);

    pdrm_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .cfg    (cfg)
    );

    pdrm_lane u_lane1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .check  (check),
        .pump_on(item.pump1_on),
        .level  (item.tank1_level),
        .now_ms (item.now_ms),
        .cfg    (cfg),
        .dry_run(dry1)
    );

    pdrm_lane u_lane2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .check  (check),
        .pump_on(item.pump2_on),
        .level  (item.tank2_level),
        .now_ms (item.now_ms),
        .cfg    (cfg),
        .dry_run(dry2)
    );

    pdrm_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .req_type        (item.req_type),
        .now_ms          (item.now_ms),
        .tank1_level     (item.tank1_level),
        .tank2_level     (item.tank2_level),
        .button_pressed  (item.button_pressed),
        .last_rotation_ms(item.last_rotation_ms),
        .dry1            (dry1),
        .dry2            (dry2),
        .cfg             (cfg),
        .res_ready       (result.ready),
        .res_valid       (res_valid),
        .res             (res)
    );

    assign result.valid            = res_valid;
    assign result.emergency_active = res.emergency_active;
    assign result.dry_run_pump1    = res.dry_run_pump1;
    assign result.dry_run_pump2    = res.dry_run_pump2;
    assign result.exit_cause       = res.exit_cause;
    assign result.relays_off       = res.relays_off;

`ifndef NO_ASSERTIONS
    a_dry_latches: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.dry_run_pump1 || result.dry_run_pump2)
        |-> result.relays_off && result.emergency_active)
        else $error("dry run without emergency latch or relay pulse");

    a_exit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.exit_cause != EXIT_NONE)
        |-> result.relays_off && !result.emergency_active)
        else $error("emergency exit without clearing latch");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !accept)
        else $error("item accepted over a pending result");

    a_exit_on_reset_only: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.req_type == REQ_CHECK)
        |=> result.exit_cause == EXIT_NONE)
        else $error("exit cause reported for a check item");
`endif

endmodule
